/* rtl/core/mono_comb_allpass_reverb_macros.svh */
// Assertion macros for the reverberator RTL.
`ifndef MONO_COMB_ALLPASS_REVERB_MACROS_SVH
`define MONO_COMB_ALLPASS_REVERB_MACROS_SVH
`ifndef SYNTHESIS
`define MCAR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define MCAR_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define MCAR_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define MCAR_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

/* rtl/core/mcar_pkg.sv */
package mcar_pkg;

  localparam int unsigned DEF_SAMPLE_RATE_HZ  = 44100;
  localparam int unsigned DEF_SAMPLE_BITS     = 24;
  localparam int unsigned DEF_COMB_FILTERS    = 8;
  localparam int unsigned DEF_ALLPASS_FILTERS = 4;
  localparam longint unsigned REF_RATE        = 44100;

  localparam int unsigned MAX_COMBS     = 8;
  localparam int unsigned MAX_ALLPASSES = 4;

  localparam int unsigned COMB_TUNE [MAX_COMBS] =
    '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
  localparam int unsigned AP_TUNE [MAX_ALLPASSES] = '{556, 441, 341, 225};

  localparam int unsigned GAIN_IN  = 983;
  localparam int unsigned ROOM_MUL = 18350;
  localparam int unsigned ROOM_ADD = 45875;
  localparam int unsigned DAMP_MUL = 26214;
  localparam int unsigned Q_ONE    = 65536;

  localparam int unsigned CFG_W  = 17;
  localparam int unsigned FB_W   = 16;
  localparam int unsigned DMP_W  = 15;

  typedef enum logic [1:0] {
    REG_ROOM = 2'd0,
    REG_DAMP = 2'd1,
    REG_WET  = 2'd2,
    REG_DRY  = 2'd3
  } mcar_reg_t;

  // Coefficients derived from the register file.
  typedef struct packed {
    logic [FB_W-1:0]  fb;
    logic [DMP_W-1:0] dmp;
    logic [CFG_W-1:0] wet;
    logic [CFG_W-1:0] dry;
  } mcar_coef_t;

  function automatic int unsigned scaled_len(input int unsigned tune,
                                             input int unsigned rate);
    longint unsigned n;
    n = (longint'(tune) * longint'(rate) + REF_RATE / 2) / REF_RATE;
    return (n < 1) ? 1 : int'(n);
  endfunction

  function automatic int unsigned comb_base(input int unsigned i, input int unsigned rate);
    int unsigned b;
    b = 0;
    for (int unsigned k = 0; k < MAX_COMBS; k++) begin
      if (k < i) b += scaled_len(COMB_TUNE[k], rate);
    end
    return b;
  endfunction

  function automatic int unsigned ap_base(input int unsigned i, input int unsigned rate);
    int unsigned b;
    b = 0;
    for (int unsigned k = 0; k < MAX_ALLPASSES; k++) begin
      if (k < i) b += scaled_len(AP_TUNE[k], rate);
    end
    return b;
  endfunction

  // Q16 product rounding, to nearest with ties toward positive infinity.
  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v >= 0) r = (v + 64'sd32768) >>> 16;
    else        r = -((-v + 64'sd32767) >>> 16);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/mcar_ram.sv */
module mcar_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/mcar_cfg.sv */
module mcar_cfg import mcar_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output mcar_coef_t       coef
);

  logic [CFG_W-1:0] v;
  logic [FB_W-1:0]  fb_next;
  logic [DMP_W-1:0] dmp_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    v = (cfg_data > CFG_W'(Q_ONE)) ? CFG_W'(Q_ONE) : cfg_data;
    fb_next  = FB_W'(((32'(v) * 32'(ROOM_MUL)) + 32'd32768) >> 16) + FB_W'(ROOM_ADD);
    dmp_next = DMP_W'(((32'(v) * 32'(DAMP_MUL)) + 32'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.fb  <= FB_W'(55050);
      coef.dmp <= DMP_W'(13107);
      coef.wet <= CFG_W'(21845);
      coef.dry <= CFG_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (mcar_reg_t'(cfg_index))
        REG_ROOM: coef.fb  <= fb_next;
        REG_DAMP: coef.dmp <= dmp_next;
        REG_WET:  coef.wet <= v;
        REG_DRY:  coef.dry <= v;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/mono_comb_allpass_reverb.sv */
// Mono reverberator: each input word is one signed audio sample, scaled by
// 0.015 and fed to up to eight damped feedback comb filters in parallel. Their
// sum goes through up to four series allpass filters of gain one half, and the
// output word is dry_level times the input plus wet_level times the reverb,
// saturated to the sample range. All delay lines live in two synchronous
// memories with separate read and write ports (one for the combs, one for
// the allpasses), and one sequencer walks the filters in turn (eight combs
// and four allpasses by default): per comb filter it reads, forms two
// products, updates the lowpass, forms the feedback product and writes back;
// per allpass filter it reads, then updates and writes back. It takes the
// word while idle, scales it in a step of its own, then forms the mix
// products and registers the output word. It returns to idle as it
// registers a result, so it can take the next word even if the previous
// result still waits downstream. A result that is still held when the next
// one is ready keeps the block in its mix step until the receiver takes it.
// After reset a clearing pass zeroes both memories, one entry per cycle,
// over as many addresses as the larger memory has entries (11040 at
// 44.1 kHz); no input word is taken during it, while configuration writes
// are accepted at any time. The user must see that registers are written
// only while the block is idle; the block itself does not enforce it.
module mono_comb_allpass_reverb import mcar_pkg::*; #(
  parameter int unsigned SAMPLE_RATE_HZ  = DEF_SAMPLE_RATE_HZ,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS,
  parameter int unsigned COMB_FILTERS    = DEF_COMB_FILTERS,
  parameter int unsigned ALLPASS_FILTERS = DEF_ALLPASS_FILTERS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

`include "mono_comb_allpass_reverb_macros.svh"

  // Memory sizes follow the sample rate; each line sits at a fixed base.
  localparam int unsigned COMB_DEPTH = int'((64'd11024 * SAMPLE_RATE_HZ) / REF_RATE) + 16;
  localparam int unsigned AP_DEPTH   = int'((64'd1563 * SAMPLE_RATE_HZ) / REF_RATE) + 8;
  localparam int unsigned CAW = $clog2(COMB_DEPTH);
  localparam int unsigned AAW = $clog2(AP_DEPTH);
  localparam int unsigned CLR_DEPTH = (COMB_DEPTH > AP_DEPTH) ? COMB_DEPTH : AP_DEPTH;
  localparam int unsigned CLR_W = $clog2(CLR_DEPTH);

  localparam int unsigned CP_W = $clog2(scaled_len(COMB_TUNE[7], SAMPLE_RATE_HZ) + 1);
  localparam int unsigned AP_W = $clog2(scaled_len(AP_TUNE[0], SAMPLE_RATE_HZ) + 1);

  localparam int unsigned CI_W = (COMB_FILTERS > 1) ? $clog2(COMB_FILTERS) : 1;
  localparam int unsigned AI_W = (ALLPASS_FILTERS > 1) ? $clog2(ALLPASS_FILTERS) : 1;
  localparam int unsigned FI_W = (CI_W > AI_W) ? CI_W : AI_W;

  localparam int unsigned SR = SAMPLE_RATE_HZ;
  localparam int unsigned COMB_LEN [MAX_COMBS] = '{
    scaled_len(COMB_TUNE[0], SR), scaled_len(COMB_TUNE[1], SR),
    scaled_len(COMB_TUNE[2], SR), scaled_len(COMB_TUNE[3], SR),
    scaled_len(COMB_TUNE[4], SR), scaled_len(COMB_TUNE[5], SR),
    scaled_len(COMB_TUNE[6], SR), scaled_len(COMB_TUNE[7], SR)};
  localparam int unsigned COMB_BASE [MAX_COMBS] = '{
    comb_base(0, SR), comb_base(1, SR), comb_base(2, SR), comb_base(3, SR),
    comb_base(4, SR), comb_base(5, SR), comb_base(6, SR), comb_base(7, SR)};
  localparam int unsigned AP_LEN [MAX_ALLPASSES] = '{
    scaled_len(AP_TUNE[0], SR), scaled_len(AP_TUNE[1], SR),
    scaled_len(AP_TUNE[2], SR), scaled_len(AP_TUNE[3], SR)};
  localparam int unsigned AP_BASE [MAX_ALLPASSES] = '{
    ap_base(0, SR), ap_base(1, SR), ap_base(2, SR), ap_base(3, SR)};

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  typedef enum logic [11:0] {
    ST_CLEAR   = 12'b000000000001,
    ST_IDLE    = 12'b000000000010,
    ST_PREP    = 12'b000000000100,
    ST_C_RD    = 12'b000000001000,
    ST_C_MUL   = 12'b000000010000,
    ST_C_LP    = 12'b000000100000,
    ST_C_FB    = 12'b000001000000,
    ST_C_WR    = 12'b000010000000,
    ST_A_RD    = 12'b000100000000,
    ST_A_UPD   = 12'b001000000000,
    ST_MIX_MUL = 12'b010000000000,
    ST_MIX_OUT = 12'b100000000000
  } state_t;

  state_t state;
  mcar_coef_t coef;

  logic [CLR_W-1:0]        clr;
  logic [FI_W-1:0]         fi;
  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [31:0]      x;
  logic signed [34:0]      sum;
  logic signed [31:0]      wet;
  logic signed [31:0]      lp   [COMB_FILTERS];
  logic [CP_W-1:0]         cpos [COMB_FILTERS];
  logic [AP_W-1:0]         apos [ALLPASS_FILTERS];
  logic signed [49:0]      pa, pb, pc, pw;
  logic signed [SAMPLE_BITS+17:0] pd;

  logic [CI_W-1:0]         ci;
  logic [AI_W-1:0]         ai;
  logic [2:0]              ct;
  logic [1:0]              at;
  logic [CP_W-1:0]         cpos_next;
  logic [AP_W-1:0]         apos_next;

  logic                    c_we, c_re, a_we, a_re;
  logic [CAW-1:0]          c_addr, c_waddr;
  logic [AAW-1:0]          a_addr, a_waddr;
  logic [31:0]             c_wdata, a_wdata, c_rdata, a_rdata;
  logic signed [31:0]      o, b;
  logic signed [63:0]      y;

  mcar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  mcar_ram #(.DEPTH(COMB_DEPTH), .WIDTH(32)) u_comb_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_addr),
    .rdata (c_rdata)
  );

  mcar_ram #(.DEPTH(AP_DEPTH), .WIDTH(32)) u_ap_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (a_re),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  // Filter index into the arrays, and into the constant tables.
  assign ci = fi[CI_W-1:0];
  assign ai = fi[AI_W-1:0];
  assign ct = 3'(fi);
  assign at = 2'(fi);
  assign o  = $signed(c_rdata);
  assign b  = $signed(a_rdata);

  // The position of a filter only moves at its write-back, so the same
  // address serves the read and the later write of that filter.
  always_comb begin
    c_addr    = CAW'(COMB_BASE[ct] + 32'(cpos[ci]));
    a_addr    = AAW'(AP_BASE[at] + 32'(apos[ai]));
    cpos_next = (32'(cpos[ci]) + 1 >= COMB_LEN[ct]) ? '0 : cpos[ci] + 1'b1;
    apos_next = (32'(apos[ai]) + 1 >= AP_LEN[at]) ? '0 : apos[ai] + 1'b1;

    c_re = (state == ST_C_RD);
    a_re = (state == ST_A_RD);

    if (state == ST_CLEAR) begin
      c_we    = (32'(clr) < COMB_DEPTH);
      c_waddr = clr[CAW-1:0];
      c_wdata = '0;
      a_we    = (32'(clr) < AP_DEPTH);
      a_waddr = clr[AAW-1:0];
      a_wdata = '0;
    end else begin
      c_we    = (state == ST_C_WR);
      c_waddr = c_addr;
      c_wdata = sat32(64'(x) + rnd_q16(64'(pc)));
      a_we    = (state == ST_A_UPD);
      a_waddr = a_addr;
      a_wdata = sat32(64'(wet) + rnd_q16(64'(b) <<< 15));
    end

    y = rnd_q16(64'(pd)) + rnd_q16(64'(pw));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      fi        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < COMB_FILTERS; i++) begin
        lp[i]   <= '0;
        cpos[i] <= '0;
      end
      for (int i = 0; i < ALLPASS_FILTERS; i++) begin
        apos[i] <= '0;
      end
    end else begin
      // The mix step drives the valid flag itself when it finishes a word.
      if (out_valid && !out_stall && state != ST_MIX_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr == CLR_W'(CLR_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            s     <= sample_in;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          x     <= sat32(rnd_q16(64'(s) * 64'sd983));
          sum   <= '0;
          fi    <= '0;
          state <= ST_C_RD;
        end
        ST_C_RD: begin
          state <= ST_C_MUL;
        end
        ST_C_MUL: begin
          pa    <= o * $signed({1'b0, 17'(Q_ONE) - 17'(coef.dmp)});
          pb    <= lp[ci] * $signed({1'b0, coef.dmp});
          sum   <= sum + 35'(o);
          state <= ST_C_LP;
        end
        ST_C_LP: begin
          lp[ci] <= sat32(rnd_q16(64'(pa)) + rnd_q16(64'(pb)));
          state  <= ST_C_FB;
        end
        ST_C_FB: begin
          pc    <= lp[ci] * $signed({1'b0, coef.fb});
          state <= ST_C_WR;
        end
        ST_C_WR: begin
          cpos[ci] <= cpos_next;
          if (fi == FI_W'(COMB_FILTERS - 1)) begin
            fi    <= '0;
            wet   <= sat32(64'(sum));
            state <= ST_A_RD;
          end else begin
            fi    <= fi + 1'b1;
            state <= ST_C_RD;
          end
        end
        ST_A_RD: begin
          state <= ST_A_UPD;
        end
        ST_A_UPD: begin
          wet      <= sat32(64'(b) - 64'(wet));
          apos[ai] <= apos_next;
          if (fi == FI_W'(ALLPASS_FILTERS - 1)) begin
            fi    <= '0;
            state <= ST_MIX_MUL;
          end else begin
            fi    <= fi + 1'b1;
            state <= ST_A_RD;
          end
        end
        ST_MIX_MUL: begin
          pd    <= s * $signed({1'b0, coef.dry});
          pw    <= wet * $signed({1'b0, coef.wet});
          state <= ST_MIX_OUT;
        end
        ST_MIX_OUT: begin
          // Wait while the previous result is still held downstream.
          if (!out_valid || !out_stall) begin
            if (y > SMAX)      sample_out <= SAMPLE_BITS'(SMAX);
            else if (y < SMIN) sample_out <= SAMPLE_BITS'(SMIN);
            else               sample_out <= SAMPLE_BITS'(y);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // A taken word always starts the scaling step.
  `MCAR_ASSERT(a_accept_prep, clk, rst, (in_valid && !in_stall) |=> (state == ST_PREP), "accepted word did not start processing")
  // Delay memories are written only by the clearing pass or a filter write-back.
  `MCAR_ASSERT(a_comb_we_src, clk, rst, c_we |-> (state == ST_CLEAR || state == ST_C_WR), "stray comb memory write")
  `MCAR_ASSERT(a_ap_we_src, clk, rst, a_we |-> (state == ST_CLEAR || state == ST_A_UPD), "stray allpass memory write")
  // A new result appears only from the mix step.
  `MCAR_ASSERT(a_out_src, clk, rst, $rose(out_valid) |-> $past(state == ST_MIX_OUT), "result without mix step")
  // Comb position stays inside its line when read.
  `MCAR_ASSERT(a_cpos_bound, clk, rst, (state == ST_C_RD) |-> (32'(cpos[ci]) < COMB_LEN[ct]), "comb position out of range")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Self-checking bench for the mono comb/allpass reverberator.
// A scoreboard object keeps its own copy of every delay line, lowpass store
// and register, predicts one output word per accepted input word, and checks
// the output words in order. Plain tasks drive the sample and register
// channels, while a separate process plays a randomly stalling receiver.

import mcar_pkg::*;

class reverb_scoreboard;
  // Delay lines sized for the longest tuning; each filter wraps at its own length.
  int comb_line [MAX_COMBS][2048];
  int comb_lp   [MAX_COMBS];
  int comb_pos  [MAX_COMBS];
  int comb_size [MAX_COMBS];
  int ap_line   [MAX_ALLPASSES][1024];
  int ap_pos    [MAX_ALLPASSES];
  int ap_size   [MAX_ALLPASSES];
  longint room, damp, wet_gain, dry_gain;
  logic [23:0] expected_words [$];
  int errors;
  int checked;

  function new();
    longint n;
    for (int i = 0; i < MAX_COMBS; i++) begin
      n = (longint'(COMB_TUNE[i]) * DEF_SAMPLE_RATE_HZ + REF_RATE / 2) / REF_RATE;
      comb_size[i] = (n < 1) ? 1 : int'(n);
      comb_lp[i] = 0;
      comb_pos[i] = 0;
      foreach (comb_line[i][k]) comb_line[i][k] = 0;
    end
    for (int i = 0; i < MAX_ALLPASSES; i++) begin
      n = (longint'(AP_TUNE[i]) * DEF_SAMPLE_RATE_HZ + REF_RATE / 2) / REF_RATE;
      ap_size[i] = (n < 1) ? 1 : int'(n);
      ap_pos[i] = 0;
      foreach (ap_line[i][k]) ap_line[i][k] = 0;
    end
    room = 32768;
    damp = 32768;
    wet_gain = 21845;
    dry_gain = 65536;
    errors = 0;
    checked = 0;
  endfunction

  // Q16 product, rounded to nearest with ties toward positive infinity.
  function longint qmul(longint a, longint q);
    longint v;
    v = a * q;
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32767) >>> 16);
  endfunction

  function longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void write_register(mcar_reg_t idx, logic [16:0] value);
    longint v;
    v = (value > Q_ONE) ? Q_ONE : value;
    case (idx)
      REG_ROOM: room = v;
      REG_DAMP: damp = v;
      REG_WET:  wet_gain = v;
      REG_DRY:  dry_gain = v;
    endcase
  endfunction

  // Runs one sample through the filters and queues the expected output word.
  function void note_sample(logic signed [23:0] s_in);
    longint s, x, fb, dmp, sum, wet, o, b, y;
    s = s_in;
    fb = qmul(room, ROOM_MUL) + ROOM_ADD;
    dmp = qmul(damp, DAMP_MUL);
    x = qmul(s, GAIN_IN);
    sum = 0;
    for (int i = 0; i < DEF_COMB_FILTERS; i++) begin
      o = comb_line[i][comb_pos[i]];
      comb_lp[i] = int'(clip32(qmul(o, Q_ONE - dmp) + qmul(comb_lp[i], dmp)));
      comb_line[i][comb_pos[i]] = int'(clip32(x + qmul(comb_lp[i], fb)));
      comb_pos[i] = (comb_pos[i] + 1 >= comb_size[i]) ? 0 : comb_pos[i] + 1;
      sum += o;
    end
    wet = clip32(sum);
    for (int i = 0; i < DEF_ALLPASS_FILTERS; i++) begin
      b = ap_line[i][ap_pos[i]];
      ap_line[i][ap_pos[i]] = int'(clip32(wet + qmul(b, 32768)));
      wet = clip32(b - wet);
      ap_pos[i] = (ap_pos[i] + 1 >= ap_size[i]) ? 0 : ap_pos[i] + 1;
    end
    y = qmul(s, dry_gain) + qmul(wet, wet_gain);
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    expected_words.push_back(y[23:0]);
  endfunction

  function void check_word(logic [23:0] actual);
    logic [23:0] want;
    if (expected_words.size() == 0) begin
      $error("sample_out: unexpected word %0d with nothing pending", $signed(actual));
      errors++;
      return;
    end
    want = expected_words.pop_front();
    checked++;
    if (actual !== want) begin
      $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(actual));
      errors++;
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction
endclass

module testbench;
  localparam int LIMIT_CYCLES = 1000000;
  // Extra cycles waited after the last pending word has come out.
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [23:0] sample_in;
  logic out_valid;
  logic out_stall;
  logic signed [23:0] sample_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  reverb_scoreboard board;
  int cycle_count;
  int long_hold_request;
  bit steady_mode;
  int words_sent;
  int reg_writes;

  mono_comb_allpass_reverb uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: checks each accepted output word, then stalls for a random
  // number of cycles. A long hold request from the stimulus makes it hold
  // off for many cycles so that the block backs up and stalls its input.
  initial begin
    int stall_left;
    int long_left;
    stall_left = 0;
    long_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        board.check_word(sample_out);
        stall_left = steady_mode ? 0 : $urandom_range(0, 7);
      end
      if (long_hold_request > 0) begin
        long_left = long_hold_request;
        long_hold_request = 0;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sends one sample word. The valid line stays high when no gap is drawn,
  // so back-to-back words never see valid dropped and raised in one step.
  task automatic send_word(logic signed [23:0] s);
    int gap;
    gap = steady_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    board.note_sample(s);
    words_sent++;
  endtask

  // Lets every pending word come out, then waits out the pipeline so that
  // the block is idle before any register write.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the valid line high; the caller drops it after its last write.
  task automatic write_reg(mcar_reg_t idx, logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(idx, value);
    reg_writes++;
  endtask

  task automatic write_all(logic [CFG_W-1:0] r, logic [CFG_W-1:0] d,
                           logic [CFG_W-1:0] w, logic [CFG_W-1:0] y);
    write_reg(REG_ROOM, r);
    write_reg(REG_DAMP, d);
    write_reg(REG_WET, w);
    write_reg(REG_DRY, y);
    cfg_valid <= 1'b0;
  endtask

  // Mostly modest audio with random bits, plus full-scale words and
  // fully random 24-bit words so that every input bit toggles.
  function automatic logic signed [23:0] random_sample();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 24'sh7fffff;
    if (pick == 1) return 24'sh800000;
    if (pick < 6) return 24'($urandom());
    return 24'($signed($urandom_range(0, 131071)) - 65536);
  endfunction

  function automatic logic [CFG_W-1:0] random_gain();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) return CFG_W'(0);
    if (pick == 1) return CFG_W'(Q_ONE);
    if (pick == 2) return CFG_W'($urandom_range(Q_ONE + 1, 131071));
    return CFG_W'($urandom_range(0, Q_ONE));
  endfunction

  initial begin
    board = new();
    words_sent = 0;
    reg_writes = 0;
    long_hold_request = 0;
    steady_mode = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    sample_in = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROOM;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings: before any setup the block
    // already reverberates, so the impulse tails must match too.
    send_word(24'sh7fffff);
    send_word(24'sh800000);
    send_word(24'sh000000);
    send_word(-24'sd1);
    send_word(24'sd1);
    send_word(24'sh555555);
    send_word(24'shaaaaaa);
    for (int i = 0; i < 6; i++) send_word(24'sh7fffff);
    for (int i = 0; i < 6; i++) send_word(24'sh800000);
    drain();

    // Register values above 1.0 must saturate; full room and no damping
    // pushes the feedback to its maximum with loud input.
    write_all(17'h1ffff, 17'd0, 17'h1ffff, 17'h10001);
    for (int i = 0; i < 8; i++) send_word(i[0] ? 24'sh7fffff : 24'sh800000);
    drain();
    write_all(17'd0, CFG_W'(Q_ONE), 17'd0, 17'd0);
    send_word(24'sh7fffff);
    send_word(24'sh800000);
    drain();

    // Random phases, each but the first under a new register setting. One phase
    // runs with no idling at all, one with a long receiver hold-off.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) write_all(CFG_W'(Q_ONE), CFG_W'(Q_ONE), CFG_W'(Q_ONE), CFG_W'(Q_ONE));
      else if (ph > 0) write_all(random_gain(), random_gain(), random_gain(), random_gain());
      steady_mode = (ph == 3);
      if (ph == 2) long_hold_request = 400;
      for (int i = 0; i < 210; i++) send_word(random_sample());
      steady_mode = 1'b0;
      drain();
    end

    $display("sent %0d sample words over %0d register writes; %0d output words checked",
             words_sent, reg_writes, board.checked);
    $display("covered full-scale input, saturating settings and long receiver stalls");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* mono_comb_allpass_reverb.f */
+incdir+rtl/core
rtl/core/mcar_pkg.sv
rtl/core/mcar_ram.sv
rtl/core/mcar_cfg.sv
rtl/core/mono_comb_allpass_reverb.sv
bench/testbench.sv
